[rtl/fit_policy_block_allocator_defines.svh]
// Assertion macros shared by the allocator checker.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fpba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Sizes, codes and the control bundle shared by the allocator modules.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int NBLOCKS    = 16;
    localparam int SIZE_WIDTH = 16;

    // Widths fixed by the channel fields.
    localparam int KIND_W   = 1;
    localparam int LIDX_W   = 4;
    localparam int SIZE_W   = 16;
    localparam int CHOSEN_W = 4;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 8;

    // Derived storage widths.
    localparam int IDX_W = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int CNT_W = $clog2(NBLOCKS + 1);

    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

    localparam logic [CIDX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the selection datapath.
    typedef struct packed {
        logic             start;
        logic             rd_valid;
        logic [IDX_W-1:0] rd_idx;
        t_fit_mode        mode;
    } t_sel_ctl;

endpackage

[rtl/fpba_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator channels
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fpba_req_if;
    logic                         valid;
    logic                         ready;
    logic [fpba_pkg::KIND_W-1:0]  kind;
    logic [fpba_pkg::LIDX_W-1:0]  load_index;
    logic [fpba_pkg::SIZE_W-1:0]  size;

    modport source (output valid, kind, load_index, size, input ready);
    modport sink   (input valid, kind, load_index, size, output ready);
endinterface

interface fpba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [fpba_pkg::CHOSEN_W-1:0] chosen_block;

    modport source (output valid, granted, chosen_block, input ready);
    modport sink   (input valid, granted, chosen_block, output ready);
endinterface

interface fpba_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fpba_pkg::CIDX_W-1:0]  index;
    logic [fpba_pkg::CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fpba_cap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacity memory
// One write port and one read port with a registered read, one entry per block.
// ----------------------------------------------------------------------------
module fpba_cap_ram (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [fpba_pkg::IDX_W-1:0]      i_waddr,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0] i_wdata,
    input  logic                            i_re,
    input  logic [fpba_pkg::IDX_W-1:0]      i_raddr,
    output logic [fpba_pkg::SIZE_WIDTH-1:0] o_rdata
);

    logic [fpba_pkg::SIZE_WIDTH-1:0] r_mem [fpba_pkg::NBLOCKS];
    logic [fpba_pkg::SIZE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fpba_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit selection
// Compares each capacity read during a scan and keeps the best candidate.
// ----------------------------------------------------------------------------
module fpba_select (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fpba_pkg::t_sel_ctl              i_ctl,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0] i_size,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0] i_cap,
    output logic                            o_found,
    output logic [fpba_pkg::SIZE_WIDTH-1:0] o_best_cap,
    output logic [fpba_pkg::IDX_W-1:0]      o_best_idx
);

    logic                            r_found;
    logic [fpba_pkg::SIZE_WIDTH-1:0] r_best_cap;
    logic [fpba_pkg::IDX_W-1:0]      r_best_idx;
    logic                            take;
    logic                            better;

    always_comb begin
        case (i_ctl.mode)
            fpba_pkg::FIT_BEST:  better = i_cap < r_best_cap;
            fpba_pkg::FIT_WORST: better = i_cap > r_best_cap;
            default:             better = 1'b0;
        endcase
        // Strict compares keep the lowest index on a tie.
        take = (i_cap >= i_size) && (!r_found || better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (i_ctl.rd_valid && take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_valid && take && !i_ctl.start) begin
            r_best_cap <= i_cap;
            r_best_idx <= i_ctl.rd_idx;
        end
    end

    assign o_found    = r_found;
    assign o_best_cap = r_best_cap;
    assign o_best_idx = r_best_idx;

endmodule

[rtl/fit_policy_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Picks a block for each request by first, best or worst fit and debits it.
// ----------------------------------------------------------------------------
// A load writes the capacity memory when it is accepted and returns no response.
// A request reads one capacity per cycle. After the last read returns, or at
// once for a block count of zero, the response is registered and a chosen
// block is debited; no request is accepted meanwhile, and a finished scan
// waits for ready. Reset sets first fit and a block count of 16; the capacity
// memory is not cleared, so every block must be loaded before a request scans it.
module fit_policy_block_allocator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fpba_req_if.sink        i_req,
    fpba_rsp_if.source      o_rsp,
    fpba_cfg_if.sink        i_cfg
);

    fpba_pkg::t_state                r_state;
    fpba_pkg::t_state                n_state;
    fpba_pkg::t_fit_mode             r_fit_mode;
    logic [4:0]                      r_block_count;
    logic [fpba_pkg::CNT_W-1:0]      r_limit;
    logic [fpba_pkg::CNT_W-1:0]      n_limit;
    logic [fpba_pkg::CNT_W-1:0]      r_issue;
    logic [fpba_pkg::SIZE_WIDTH-1:0] r_size;
    logic                            r_rd_valid;
    logic                            r_rd_last;
    logic [fpba_pkg::IDX_W-1:0]      r_rd_idx;
    logic                            r_rsp_valid;
    logic                            r_granted;
    logic [fpba_pkg::CHOSEN_W-1:0]   r_chosen;

    logic                            req_fire;
    logic                            issue;
    logic                            finish;
    logic                            ram_we;
    logic [fpba_pkg::IDX_W-1:0]      ram_waddr;
    logic [fpba_pkg::SIZE_WIDTH-1:0] ram_wdata;
    logic [fpba_pkg::SIZE_WIDTH-1:0] ram_rdata;
    logic                            sel_found;
    logic [fpba_pkg::SIZE_WIDTH-1:0] sel_best_cap;
    logic [fpba_pkg::IDX_W-1:0]      sel_best_idx;
    fpba_pkg::t_sel_ctl              sel_ctl;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == fpba_pkg::ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= fpba_pkg::FIT_FIRST;
            r_block_count <= fpba_pkg::BLOCK_COUNT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fpba_pkg::REG_FIT_MODE: begin
                    r_fit_mode <= fpba_pkg::t_fit_mode'(i_cfg.data[1:0]);
                end
                fpba_pkg::REG_BLOCK_COUNT: r_block_count <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // Blocks beyond the memory are never scanned.
    always_comb begin
        if (32'(r_block_count) > fpba_pkg::NBLOCKS) begin
            n_limit = fpba_pkg::CNT_W'(fpba_pkg::NBLOCKS);
        end else begin
            n_limit = fpba_pkg::CNT_W'(r_block_count);
        end
    end

    always_comb begin
        n_state = r_state;
        issue   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            fpba_pkg::ST_IDLE: begin
                if (req_fire && (i_req.kind == fpba_pkg::KIND_ALLOC)) begin
                    n_state = (n_limit == '0) ? fpba_pkg::ST_FINISH : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN: begin
                issue = (r_issue < r_limit);
                if (r_rd_valid && r_rd_last) begin
                    n_state = fpba_pkg::ST_FINISH;
                end
            end
            fpba_pkg::ST_FINISH: begin
                // Hold the result until the output register is free.
                if (!r_rsp_valid || o_rsp.ready) begin
                    finish  = 1'b1;
                    n_state = fpba_pkg::ST_IDLE;
                end
            end
            default: n_state = fpba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan sequencing: one read issued per cycle, with the data from the registered read returned in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= '0;
            r_limit    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            r_rd_last  <= issue && ((r_issue + 1'b1) == r_limit);
            if (req_fire) begin
                r_issue <= '0;
                r_limit <= n_limit;
            end else if (issue) begin
                r_issue <= r_issue + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_issue[fpba_pkg::IDX_W-1:0];
        end
        if (req_fire) begin
            r_size <= fpba_pkg::SIZE_WIDTH'(i_req.size);
        end
    end

    // Memory writes come from loads in idle and from the write-back at the end.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sel_best_idx;
        ram_wdata = sel_best_cap - r_size;
        if (finish) begin
            ram_we = sel_found;
        end else if (req_fire && (i_req.kind == fpba_pkg::KIND_LOAD)) begin
            ram_we    = (32'(i_req.load_index) < fpba_pkg::NBLOCKS);
            ram_waddr = fpba_pkg::IDX_W'(i_req.load_index);
            ram_wdata = fpba_pkg::SIZE_WIDTH'(i_req.size);
        end
    end

    fpba_cap_ram u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_issue[fpba_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign sel_ctl.start    = req_fire;
    assign sel_ctl.rd_valid = r_rd_valid;
    assign sel_ctl.rd_idx   = r_rd_idx;
    assign sel_ctl.mode     = r_fit_mode;

    fpba_select u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sel_ctl),
        .i_size     (r_size),
        .i_cap      (ram_rdata),
        .o_found    (sel_found),
        .o_best_cap (sel_best_cap),
        .o_best_idx (sel_best_idx)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (finish) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_granted <= sel_found;
            r_chosen  <= sel_found ? fpba_pkg::CHOSEN_W'(sel_best_idx) : '0;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.granted      = r_granted;
    assign o_rsp.chosen_block = r_chosen;

endmodule

[rtl/fpba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_defines.svh"

module fpba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic [fpba_pkg::KIND_W-1:0]   i_req_kind,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_granted,
    input logic [fpba_pkg::CHOSEN_W-1:0] i_rsp_chosen
);

    logic alloc_fire;
    assign alloc_fire = i_req_valid && i_req_ready && (i_req_kind == fpba_pkg::KIND_ALLOC);

    // A stalled response holds its value.
    `FPBA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_granted) && $stable(i_rsp_chosen), "response changed while stalled")

    // A refused request reports block zero.
    `FPBA_ASSERT_NOW(a_deny_zero, i_rsp_valid && !i_rsp_granted, i_rsp_chosen == '0, "denied response carries a block index")

    // A request keeps the allocator busy for at least the following cycle.
    `FPBA_ASSERT_NEXT(a_busy_after_req, alloc_fire, !i_req_ready, "request accepted during a scan")

    // No response can appear in the cycle right after a request is taken.
    `FPBA_ASSERT_NEXT(a_no_instant_rsp, alloc_fire, !$rose(i_rsp_valid), "response appeared without a scan")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_kind    (i_req.kind),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_granted (o_rsp.granted),
    .i_rsp_chosen  (o_rsp.chosen_block)
);
